### hw/rtl/hrb_pkg.sv
// shared types and constants for the heightfield radial brush
package hrb_pkg;

  localparam logic [1:0] REQ_FLAT  = 2'd0;
  localparam logic [1:0] REQ_ATTEN = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;   // unused request code, answered with a miss

  localparam logic [2:0] REG_PITCH  = 3'd0;
  localparam logic [2:0] REG_RADIUS = 3'd1;
  localparam logic [2:0] REG_LIFT   = 3'd2;
  localparam logic [2:0] REG_RANGE  = 3'd3;
  localparam logic [2:0] REG_HIGH   = 3'd4;
  localparam logic [2:0] REG_LOW    = 3'd5;

  // divider operation codes
  typedef enum logic [1:0] {
    OP_SQRT,
    OP_DIV
  } div_op_t;

  typedef struct packed {
    logic        start;
    div_op_t     op;
    logic [63:0] num;
    logic [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quo;
  } div_rsp_t;

endpackage

### hw/rtl/hrb_unit.sv
// shared bit-serial unit: 64-bit integer square root or 64/32 division
module hrb_unit (
  input  logic             clk,
  input  logic             rst,
  input  hrb_pkg::div_req_t req,
  output hrb_pkg::div_rsp_t rsp
);
  import hrb_pkg::*;

  logic        busy;
  logic        done;
  div_op_t     op;
  logic [5:0]  step;
  logic [63:0] num;
  logic [31:0] den;
  logic [64:0] rem;
  logic [63:0] quo;
  logic [65:0] rem_sh;
  logic [65:0] trial;
  logic        take;

  // restoring division shifts one numerator bit per cycle; the root shifts two
  always_comb begin
    if (op == OP_SQRT) begin
      rem_sh = {rem[63:0], num[63:62]};
      trial  = {quo[63:0], 2'b01};
    end else begin
      rem_sh = {rem, num[63]};
      trial  = {34'd0, den};
    end
    take = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        num  <= req.num;
        den  <= req.den;
        rem  <= '0;
        quo  <= '0;
        step <= '0;
      end else if (busy) begin
        rem  <= take ? 65'(rem_sh - trial) : rem_sh[64:0];
        quo  <= {quo[62:0], take};
        num  <= (op == OP_SQRT) ? {num[61:0], 2'b00} : {num[62:0], 1'b0};
        step <= step + 6'd1;
        if ((op == OP_SQRT && step == 6'd31) || step == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, quo: quo};
endmodule

### hw/rtl/heightfield_radial_brush.sv
// top level of the heightfield radial brush
//
//  channel | direction | word
//  s_axis  | in        | tdata {cell_z[9:5], cell_x[4:0]}, tuser req_type
//  m_axis  | out       | tdata {alpha, blue, green, red, height, hit}, 7 pad bits
//  cfg     | in        | cfg_we, cfg_index, cfg_data, no read-back
//
// a stamp sweeps every cell through S_CELL, S_RD, S_CHECK and S_WRITE for a
// cell out of reach or a flat raise; an attenuated cell in range costs one
// 32-step square root and one 64-step division on the shared unit
// a read runs one division per colour channel;
// white, full high or full low colour skip the divisions
// after reset a clearing pass writes zero to every cell, during which no word
// is accepted
// one word in flight at a time; s_axis_tready drops until the result is taken
module heightfield_radial_brush #(
  parameter int GRID_WIDTH = 16,
  parameter int GRID_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // cell_x, cell_z, zero pad
  input  logic [1:0]  s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // hit, height, red, green, blue, alpha, zero pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import hrb_pkg::*;

  localparam int CELLS = GRID_WIDTH * GRID_DEPTH;
  localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CELL, S_RD, S_CHECK, S_SQRT, S_DIV, S_WRITE,
    S_CREAD, S_CLOAD, S_CSTART, S_CDIV, S_OUT
  } state_t;

  state_t state;

  // configuration registers
  logic [15:0] cell_pitch, brush_radius, color_range;
  logic signed [15:0] lift_amount;
  logic [31:0] high_color, low_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_pitch   <= 16'd256;
      brush_radius <= 16'd512;
      lift_amount  <= 16'sd256;
      color_range  <= 16'd512;
      high_color   <= 32'hFF0000FF;
      low_color    <= 32'h0000FFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PITCH:  cell_pitch   <= cfg_data[15:0];
        REG_RADIUS: brush_radius <= cfg_data[15:0];
        REG_LIFT:   lift_amount  <= cfg_data[15:0];
        REG_RANGE:  color_range  <= cfg_data[15:0];
        REG_HIGH:   high_color   <= cfg_data;
        REG_LOW:    low_color    <= cfg_data;
        default: ;
      endcase
    end
  end

  // height memory
  logic [15:0] mem [CELLS];
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [15:0]   wdata, rdata;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // request and sweep state
  logic [1:0]  rtype;
  logic [4:0]  cx, cz, x, z;
  logic        hit;
  logic signed [15:0] hgt;
  logic [7:0]  ch [4];
  logic [1:0]  chn;
  logic [10:0] d2;
  logic [31:0] p2, r2;
  logic [42:0] dp2;
  logic [15:0] mag;
  logic [31:0] col;
  logic signed [15:0] cur;
  logic signed [16:0] raise;
  logic        lift_neg;

  div_req_t ureq;
  div_rsp_t ursp;
  hrb_unit u_unit (.clk(clk), .rst(rst), .req(ureq), .rsp(ursp));

  // offsets of the current cell from the centre
  logic signed [11:0] ddx, ddz;
  assign ddx = 12'(x) - 12'(cx);
  assign ddz = 12'(z) - 12'(cz);

  logic [AW-1:0] cell_addr;
  assign cell_addr = AW'(32'(z) * 32'(GRID_WIDTH) + 32'(x));

  logic signed [17:0] sum;
  assign sum = 18'(cur) + 18'(raise);

  logic last_cell;
  assign last_cell = (32'(x) == GRID_WIDTH - 1) && (32'(z) == GRID_DEPTH - 1);

  // lift magnitude, 32768 fits for the most negative lift
  logic [16:0] lift_mag;
  assign lift_mag = lift_amount[15] ? 17'(-(17'(lift_amount))) : 17'(lift_amount);

  // magnitude and target colour of the cell just read
  logic [15:0] rmag;
  logic [31:0] rcol;
  assign rmag = rdata[15] ? 16'(-rdata) : rdata;
  assign rcol = rdata[15] ? low_color : high_color;

  logic [7:0] cchan;
  always_comb begin
    case (chn)
      2'd0:    cchan = col[31:24];
      2'd1:    cchan = col[23:16];
      2'd2:    cchan = col[15:8];
      default: cchan = col[7:0];
    endcase
  end

  // blend numerator 255*(range-mag)+c*mag plus half the range for rounding
  logic [31:0] bnum;
  assign bnum = 32'd255 * 32'(color_range - mag) + 32'(cchan) * 32'(mag)
              + 32'(color_range[15:1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      s_axis_tready <= 1'b0;
      m_axis_tvalid <= 1'b0;
      we            <= 1'b0;
      ureq.start    <= 1'b0;
      x <= '0;
      z <= '0;
    end else begin
      we         <= 1'b0;
      ureq.start <= 1'b0;
      case (state)
        S_CLEAR: begin
          we    <= 1'b1;
          waddr <= cell_addr;
          wdata <= '0;
          if (last_cell) begin
            state         <= S_IDLE;
            s_axis_tready <= 1'b1;
          end else if (32'(x) == GRID_WIDTH - 1) begin
            x <= '0;
            z <= z + 5'd1;
          end else begin
            x <= x + 5'd1;
          end
        end
        S_IDLE: if (s_axis_tvalid) begin
          s_axis_tready <= 1'b0;
          rtype <= s_axis_tuser;
          cx    <= s_axis_tdata[4:0];
          cz    <= s_axis_tdata[9:5];
          hit   <= (32'(s_axis_tdata[4:0]) < GRID_WIDTH) &&
                   (32'(s_axis_tdata[9:5]) < GRID_DEPTH) && s_axis_tuser != REQ_NONE;
          hgt   <= '0;
          for (int i = 0; i < 4; i++) ch[i] <= '0;
          p2    <= 32'(cell_pitch) * 32'(cell_pitch);
          r2    <= 32'(brush_radius) * 32'(brush_radius);
          x <= '0;
          z <= '0;
          if (s_axis_tuser == REQ_NONE || 32'(s_axis_tdata[4:0]) >= GRID_WIDTH ||
              32'(s_axis_tdata[9:5]) >= GRID_DEPTH) begin
            state <= S_OUT;
          end else if (s_axis_tuser == REQ_READ) begin
            raddr <= AW'(32'(s_axis_tdata[9:5]) * 32'(GRID_WIDTH) +
                         32'(s_axis_tdata[4:0]));
            state <= S_CREAD;
            chn   <= '0;
          end else begin
            state <= S_CELL;
          end
        end
        S_CELL: begin
          raddr <= cell_addr;
          d2    <= 11'(ddx * ddx + ddz * ddz);
          state <= S_RD;
        end
        S_RD: begin
          dp2   <= 43'(d2) * 43'(p2);
          state <= S_CHECK;
        end
        S_CHECK: begin
          cur <= rdata;
          if (dp2 > 43'(r2)) begin
            state <= S_WRITE;
            raise <= '0;
          end else if (rtype == REQ_FLAT || brush_radius == 16'd0) begin
            raise <= 17'(lift_amount);
            state <= S_WRITE;
          end else begin
            ureq.start <= 1'b1;
            ureq.op    <= OP_SQRT;
            ureq.num   <= 64'(dp2);
            ureq.den   <= '0;
            state      <= S_SQRT;
          end
        end
        S_SQRT: if (ursp.done) begin
          lift_neg   <= lift_amount[15];
          state      <= S_DIV;
          ureq.start <= 1'b1;
          ureq.op    <= OP_DIV;
          // magnitude division, sign restored below (truncation toward zero)
          ureq.num   <= 64'(32'(lift_mag) * 32'(brush_radius - ursp.quo[15:0]));
          ureq.den   <= 32'(brush_radius);
        end
        S_DIV: if (ursp.done) begin
          raise <= lift_neg ? -17'(ursp.quo[16:0]) : 17'(ursp.quo[16:0]);
          state <= S_WRITE;
        end
        S_WRITE: begin
          we    <= 1'b1;
          waddr <= raddr;
          wdata <= (sum > 18'sd32767) ? 16'h7FFF :
                   (sum < -18'sd32768) ? 16'h8000 : sum[15:0];
          if (last_cell) begin
            state <= S_OUT;
          end else begin
            state <= S_CELL;
            if (32'(x) == GRID_WIDTH - 1) begin
              x <= '0;
              z <= z + 5'd1;
            end else begin
              x <= x + 5'd1;
            end
          end
        end
        S_CREAD: begin
          // wait for the registered read
          state <= S_CLOAD;
        end
        S_CLOAD: begin
          hgt <= rdata;
          mag <= rmag;
          col <= rcol;
          if (rdata == 16'd0) begin
            // zero height reads white
            for (int i = 0; i < 4; i++) ch[i] <= 8'hFF;
            state <= S_OUT;
          end else if (rmag > color_range) begin
            // beyond the range: the full colour
            for (int i = 0; i < 4; i++) ch[i] <= rcol[31-8*i -: 8];
            state <= S_OUT;
          end else begin
            state <= S_CSTART;
          end
        end
        S_CSTART: begin
          ureq.start <= 1'b1;
          ureq.op    <= OP_DIV;
          ureq.num   <= 64'(bnum);
          ureq.den   <= 32'(color_range);
          state      <= S_CDIV;
        end
        S_CDIV: if (ursp.done) begin
          ch[chn] <= ursp.quo[7:0];
          chn     <= chn + 2'd1;
          state   <= (chn == 2'd3) ? S_OUT : S_CSTART;
        end
        S_OUT: begin
          if (!m_axis_tvalid) begin
            m_axis_tvalid <= 1'b1;
          end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            s_axis_tready <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {7'd0, ch[3], ch[2], ch[1], ch[0], hgt, hit};
endmodule

### hw/rtl/hrb_checker.sv
// port-level checks for the heightfield radial brush, bound to the top level
module hrb_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result word dropped or changed while stalled");

  a_one: assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a result is pending");

  a_take: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second word accepted before result");

  a_miss: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[55:1] == '0)
    else $error("miss result carries data");
endmodule

bind heightfield_radial_brush hrb_checker u_hrb_checker (
  .clk(clk), .rst(rst),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

### bench/testbench.sv
// self-checking testbench for the heightfield radial brush
`timescale 1ns / 1ps

module testbench;
  import hrb_pkg::*;

  localparam int GRID_WIDTH = 16;
  localparam int GRID_DEPTH = 16;
  localparam int GRID_CELLS = GRID_WIDTH * GRID_DEPTH;
  localparam logic [2:0] REG_SPARE = 3'd6;    // index past the register file

  // result word as it sits in m_axis_tdata[48:0], hit in the lowest bit
  typedef struct packed {
    logic [7:0]         alpha;
    logic [7:0]         blue;
    logic [7:0]         green;
    logic [7:0]         red;
    logic signed [15:0] height;
    logic               hit;
  } cell_result_t;

  // shadow of the grid and its registers; predicts the result of every word
  class brush_scoreboard;
    int          heights [GRID_CELLS];
    int unsigned pitch, radius, span;
    int          lift;
    logic [31:0] high_rgba, low_rgba;
    cell_result_t expected_results [$];
    int          errors, stamps, reads, misses;

    function new();
      foreach (heights[i]) heights[i] = 0;
      pitch = 256; radius = 512; lift = 256; span = 512;
      high_rgba = 32'hFF0000FF; low_rgba = 32'h0000FFFF;
      errors = 0; stamps = 0; reads = 0; misses = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        REG_PITCH:  pitch = value[15:0];
        REG_RADIUS: radius = value[15:0];
        REG_LIFT:   lift = $signed(value[15:0]);
        REG_RANGE:  span = value[15:0];
        REG_HIGH:   high_rgba = value;
        REG_LOW:    low_rgba = value;
        default: ;
      endcase
    endfunction

    // floor square root, bit by bit from the top
    function longint unsigned floor_root(longint unsigned v);
      longint unsigned res, trial;
      res = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = res | (64'd1 << b);
        if (trial * trial <= v) res = trial;
      end
      return res;
    endfunction

    // one channel blended from white toward c, rounded half up
    function logic [7:0] blend_channel(int unsigned mag, int unsigned c);
      int unsigned num;
      num = 255 * (span - mag) + c * mag;
      return 8'((num + span / 2) / span);
    endfunction

    function logic [31:0] shade(int h);
      logic [31:0] tint, col;
      int unsigned mag;
      if (h == 0) return 32'hFFFFFFFF;
      tint = (h > 0) ? high_rgba : low_rgba;
      mag = (h > 0) ? h : -h;
      if (mag > span) return tint;
      for (int j = 0; j < 4; j++)
        col[8*j +: 8] = blend_channel(mag, tint[8*j +: 8]);
      return col;
    endfunction

    function void apply_stamp(int cx, int cz, bit atten);
      longint unsigned d2, r2, reach;
      longint prod;
      int dx, dz, raise, sum;
      r2 = longint'(radius) * radius;
      for (int z = 0; z < GRID_DEPTH; z++) begin
        for (int x = 0; x < GRID_WIDTH; x++) begin
          dx = x - cx;
          dz = z - cz;
          d2 = longint'(dx * dx + dz * dz) * pitch * pitch;
          if (d2 <= r2) begin
            if (!atten || radius == 0) begin
              raise = lift;
            end else begin
              reach = floor_root(d2);
              prod = longint'(lift) * (longint'(radius) - longint'(reach));
              raise = int'(prod / longint'(radius));   // truncates toward zero
            end
            sum = heights[z*GRID_WIDTH + x] + raise;
            if (sum > 32767) sum = 32767;
            if (sum < -32768) sum = -32768;
            heights[z*GRID_WIDTH + x] = sum;
          end
        end
      end
    endfunction

    // accepted request word: update the shadow grid, queue what must come back
    function void note_request(logic [1:0] kind, logic [4:0] cx, logic [4:0] cz);
      cell_result_t r;
      logic [31:0] col;
      int h;
      r = '0;
      if (kind != REQ_NONE) begin
        r.hit = (cx < GRID_WIDTH) && (cz < GRID_DEPTH);
        if (!r.hit) begin
          misses++;
        end else if (kind == REQ_READ) begin
          reads++;
          h = heights[cz*GRID_WIDTH + cx];
          col = shade(h);
          r.height = 16'(h);
          {r.red, r.green, r.blue, r.alpha} = col;
        end else begin
          stamps++;
          apply_stamp(cx, cz, kind == REQ_ATTEN);
        end
      end
      expected_results = {expected_results, r};
    endfunction

    function void check_result(cell_result_t got);
      cell_result_t want;
      if (expected_results.size() == 0) begin
        $error("result word with nothing outstanding: %h", got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.hit !== want.hit) begin
        $error("hit: expected %0d, got %0d", want.hit, got.hit); errors++;
      end
      if (got.height !== want.height) begin
        $error("height: expected %0d, got %0d", want.height, got.height); errors++;
      end
      if (got.red !== want.red) begin
        $error("red: expected %0d, got %0d", want.red, got.red); errors++;
      end
      if (got.green !== want.green) begin
        $error("green: expected %0d, got %0d", want.green, got.green); errors++;
      end
      if (got.blue !== want.blue) begin
        $error("blue: expected %0d, got %0d", want.blue, got.blue); errors++;
      end
      if (got.alpha !== want.alpha) begin
        $error("alpha: expected %0d, got %0d", want.alpha, got.alpha); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;    // cell_x, cell_z, zero pad
  logic [1:0]  s_axis_tuser;    // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;    // hit, height, red, green, blue, alpha, zero pad
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  brush_scoreboard grid_model = new();
  bit calm;                     // when set neither side idles

  heightfield_radial_brush #(
    .GRID_WIDTH(GRID_WIDTH),
    .GRID_DEPTH(GRID_DEPTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // a stamp is the costliest word; this timeout covers every word at that cost many times
  initial begin
    #1s;
    $display("TB_ERROR");
    $finish;
  end

  // result side: take words, stall at random
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready)
        grid_model.check_result(m_axis_tdata[48:0]);
      m_axis_tready <= calm || ($urandom_range(99) >= 34);
    end
  end

  function bit take_break();
    return !calm && ($urandom_range(99) < 34);
  endfunction

  // register write, only issued while the block holds no word
  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    grid_model.set_reg(idx, value);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic wait_drained();
    while (grid_model.expected_results.size() != 0) @(posedge clk);
  endtask

  // offer one request word and hold it until the block takes it
  task automatic send_request(logic [1:0] kind, logic [4:0] cx, logic [4:0] cz);
    if (take_break()) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {6'd0, cz, cx};
    do @(posedge clk); while (!s_axis_tready);
    grid_model.note_request(kind, cx, cz);
  endtask

  task automatic send_random(int count);
    logic [1:0] kind;
    logic [4:0] cx, cz;
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      kind = (pick < 40) ? REQ_READ : (pick < 65) ? REQ_FLAT :
             (pick < 92) ? REQ_ATTEN : REQ_NONE;
      cx = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 16)) : 5'($urandom_range(15));
      cz = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 16)) : 5'($urandom_range(15));
      send_request(kind, cx, cz);
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    // clearing pass: wait until the block is ready for a word
    do @(posedge clk); while (!s_axis_tready);

    // directed: reset settings, corners, centre, outside cells, unused code
    send_request(REQ_READ, 5'd0, 5'd0);             // untouched cell reads white
    send_request(REQ_FLAT, 5'd0, 5'd0);
    send_request(REQ_FLAT, 5'd15, 5'd15);
    send_request(REQ_ATTEN, 5'd8, 5'd7);
    send_request(REQ_READ, 5'd0, 5'd1);
    send_request(REQ_READ, 5'd8, 5'd7);
    send_request(REQ_READ, 5'd15, 5'd15);
    send_request(REQ_FLAT, 5'd16, 5'd3);            // centre off the grid
    send_request(REQ_ATTEN, 5'd3, 5'd31);
    send_request(REQ_READ, 5'd31, 5'd31);
    send_request(REQ_NONE, 5'd5, 5'd5);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // directed: zero pitch and radius, saturation both ways, zero colour span
    write_reg(REG_PITCH, 32'd0);
    write_reg(REG_RADIUS, 32'd0);
    write_reg(REG_LIFT, 32'h7FFF);
    write_reg(REG_RANGE, 32'd0);
    write_reg(REG_SPARE, 32'hFFFFFFFF);             // ignored index
    send_request(REQ_FLAT, 5'd4, 5'd4);
    send_request(REQ_FLAT, 5'd4, 5'd4);
    send_request(REQ_ATTEN, 5'd9, 5'd2);            // zero radius: full lift
    send_request(REQ_READ, 5'd4, 5'd4);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    write_reg(REG_LIFT, 32'h8000);
    write_reg(REG_RADIUS, 32'd300);
    send_request(REQ_ATTEN, 5'd0, 5'd15);           // zero pitch: every cell at the centre
    send_request(REQ_FLAT, 5'd1, 5'd1);
    send_request(REQ_FLAT, 5'd1, 5'd1);
    send_request(REQ_READ, 5'd2, 5'd2);
    send_request(REQ_READ, 5'd9, 5'd2);
    s_axis_tvalid <= 1'b0;
    wait_drained();

    // widest spacing and radius: only the centre and its four direct neighbours are reached
    write_reg(REG_PITCH, 32'hFFFF);
    write_reg(REG_RADIUS, 32'hFFFF);
    write_reg(REG_LIFT, 32'hFF80);
    write_reg(REG_RANGE, 32'hFFFF);
    write_reg(REG_HIGH, 32'h00000000);
    write_reg(REG_LOW, 32'hFFFFFFFF);
    send_random(22);

    // everyday settings, no idling on either side
    calm = 1'b1;
    write_reg(REG_PITCH, 32'd256);
    write_reg(REG_RADIUS, 32'd900);
    write_reg(REG_LIFT, 32'h0180);
    write_reg(REG_RANGE, 32'd2000);
    write_reg(REG_HIGH, 32'h12345678);
    write_reg(REG_LOW, 32'hA5C3F00F);
    send_random(40);
    calm = 1'b0;

    // tiny pitch, huge radius: every cell in reach, slow attenuated stamps
    write_reg(REG_PITCH, 32'd1);
    write_reg(REG_RADIUS, 32'hFFFF);
    write_reg(REG_LIFT, 32'hFE20);
    write_reg(REG_RANGE, 32'd1);
    send_random(8);

    // random settings: pitch, radius and colour span in a mid range, lift and colours anywhere
    write_reg(REG_PITCH, $urandom_range(600, 100));
    write_reg(REG_RADIUS, $urandom_range(1500, 0));
    write_reg(REG_LIFT, $urandom());
    write_reg(REG_RANGE, $urandom_range(4000, 1));
    write_reg(REG_HIGH, $urandom());
    write_reg(REG_LOW, $urandom());
    send_random(30);
    write_reg(REG_LIFT, $urandom());
    write_reg(REG_RADIUS, $urandom_range(1200, 200));
    send_random(30);

    wait_drained();
    repeat (200) @(posedge clk);
    $display("covered %0d stamps, %0d reads, %0d requests naming no cell",
             grid_model.stamps, grid_model.reads, grid_model.misses);
    $display("over six register settings incl. zero, widest and narrowest values");
    if (grid_model.errors == 0 && grid_model.expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/hrb_pkg.sv
hw/rtl/hrb_unit.sv
hw/rtl/heightfield_radial_brush.sv
hw/rtl/hrb_checker.sv
bench/testbench.sv
